// ===== hdl/lph_pkg.sv =====
// Shared types, sizes and codes for the linear-probe hash index.
// Used by linear_probe_hash_index_top and its testbench.
`timescale 1ns / 1ps
package lph_pkg;

    localparam int BUCKETS  = 1024;
    localparam int BW       = $clog2(BUCKETS);
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int HASH_W   = 64;
    localparam int CNT_W    = BW + 1;
    localparam int SLOT_W   = BW;

    localparam logic [HASH_W-1:0] HASH_EMPTY = '0;
    localparam logic [HASH_W-1:0] HASH_TOMB  = '1;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_RESERVED  = 3'd6;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [HASH_W-1:0]  probe_hash;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] value_out;
        logic [SLOT_W-1:0]  slot;
        logic [CNT_W-1:0]   entry_count;
    } t_rsp;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [SLOT_W-1:0] slot;
    } t_bucket;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [HASH_W-1:0]  hash;
    } t_dense;

endpackage

// ===== hdl/lph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // write port, then registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/linear_probe_hash_index_top.sv =====
// Top level of the linear-probe hash index: sequencer, bucket and dense stores.
// Depends on lph_pkg and lph_ram.
//
// Usage: present a request on i_req and raise start while busy is low; the
// request is taken at that edge. Exactly one result follows on o_rsp, marked
// by o_done for one cycle; the receiver cannot hold it off. busy drops in the
// cycle o_done rises, so the next request may be taken then.
// Flow: a reserved hash, an unknown op or a put over the load limit answers
// at once, without a probe. Otherwise each bucket visited is read (S_BRD)
// and checked (S_BCHK), a candidate key is compared against the dense store
// (S_DCHK), and S_END finishes. A remove that relocates the last entry runs
// a second probe (S_LRD, S_LCHK, then the probe and S_END) and ends in S_TOMB.
// The registered read port of the bucket store is why each visit needs S_BRD.
// Reset: count clears, load_limit returns to 731, a clearing pass writes all
// BUCKETS bucket entries empty with busy held high. The user must write the
// configuration (load_limit at paddr 0) over APB only while idle; not enforced.
`timescale 1ns / 1ps
module linear_probe_hash_index_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lph_pkg::t_req i_req,
    output logic          o_done,
    output lph_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int BW = lph_pkg::BW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_BRD  = 4'd2;
    localparam logic [3:0] S_BCHK = 4'd3;
    localparam logic [3:0] S_DCHK = 4'd4;
    localparam logic [3:0] S_END  = 4'd5;
    localparam logic [3:0] S_LRD  = 4'd6;
    localparam logic [3:0] S_LCHK = 4'd7;
    localparam logic [3:0] S_TOMB = 4'd8;

    logic [3:0]                   r_state;
    logic [BW-1:0]                r_idx;
    logic [BW-1:0]                r_n;
    logic [lph_pkg::CNT_W-1:0]    r_cnt;
    logic [lph_pkg::CNT_W-1:0]    r_lim;
    logic [1:0]                   r_op;
    logic [lph_pkg::HASH_W-1:0]   r_h;
    logic [lph_pkg::KEY_W-1:0]    r_k;
    logic [lph_pkg::VALUE_W-1:0]  r_v;
    logic [lph_pkg::SLOT_W-1:0]   r_hs;
    logic [BW-1:0]                r_hb;
    logic                         r_hit;
    logic                         r_tv;
    logic [BW-1:0]                r_tomb;
    logic                         r_fv;
    logic [BW-1:0]                r_free;
    lph_pkg::t_dense              r_dd;
    lph_pkg::t_dense              r_ld;
    logic                         r_reloc;
    logic [BW-1:0]                r_rb;
    logic [lph_pkg::SLOT_W-1:0]   r_rs;
    logic                         r_done;
    logic                         n_done;
    lph_pkg::t_rsp                r_rsp;

    logic                         b_we;
    logic [BW-1:0]                b_waddr;
    lph_pkg::t_bucket             b_wdata;
    lph_pkg::t_bucket             b_q;
    logic                         d_we;
    logic [BW-1:0]                d_waddr;
    lph_pkg::t_dense              d_wdata;
    logic [BW-1:0]                d_raddr;
    lph_pkg::t_dense              d_q;

    logic                         accept;
    logic                         cfg_wr;
    logic                         reserved;
    logic                         over_limit;
    logic                         early;
    logic [2:0]                   early_st;
    logic                         relocate;
    logic                         cand;
    logic                         tgt_ok;
    logic [BW-1:0]                tgt;
    logic [lph_pkg::CNT_W-1:0]    last;
    logic                         room;

    lph_ram #(.WIDTH($bits(lph_pkg::t_bucket)), .DEPTH(lph_pkg::BUCKETS)) u_bucket (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (r_idx),
        .o_rdata (b_q)
    );

    lph_ram #(.WIDTH($bits(lph_pkg::t_dense)), .DEPTH(lph_pkg::BUCKETS)) u_dense (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    // handshakes and common decode
    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign pready     = 1'b1;
    assign prdata     = 32'(r_lim);
    assign cfg_wr     = psel && penable && pwrite && !paddr[2];
    assign reserved   = (i_req.probe_hash == lph_pkg::HASH_EMPTY) ||
                        (i_req.probe_hash == lph_pkg::HASH_TOMB);
    assign over_limit = ({1'b0, r_cnt} + 12'd1) >= {1'b0, r_lim};
    assign early      = reserved || (i_req.op == lph_pkg::OP_UNUSED) ||
                        (i_req.op == lph_pkg::OP_PUT && over_limit);
    assign early_st   = reserved ? lph_pkg::ST_RESERVED :
                        (i_req.op == lph_pkg::OP_PUT && over_limit) ? lph_pkg::ST_FULL :
                        lph_pkg::ST_NOT_FOUND;
    assign relocate   = (r_op == lph_pkg::OP_REMOVE) && r_hit &&
                        ({1'b0, r_hs} != last);
    assign n_done     = (r_state == S_IDLE && accept && early) ||
                        (r_state == S_END && !r_reloc && !relocate) ||
                        (r_state == S_TOMB);
    assign cand       = (b_q.hash == r_h) && ({1'b0, b_q.slot} < r_cnt);
    assign tgt_ok     = r_tv || r_fv;
    assign tgt        = r_tv ? r_tomb : r_free;
    assign last       = r_cnt - lph_pkg::CNT_W'(1);
    assign room       = r_cnt < lph_pkg::CNT_W'(lph_pkg::BUCKETS);
    assign o_done     = r_done;
    assign o_rsp      = r_rsp;

    // memory write and dense read control
    always_comb begin
        b_we    = 1'b0;
        b_waddr = r_idx;
        b_wdata = '0;
        d_we    = 1'b0;
        d_waddr = r_hs;
        d_wdata = r_ld;
        d_raddr = b_q.slot;
        unique case (r_state)
            S_CLR: begin
                b_we = 1'b1;
            end
            S_LRD: begin
                d_raddr = last[BW-1:0];
            end
            S_END: begin
                if (r_reloc) begin
                    b_we    = r_hit;
                    b_waddr = r_hb;
                    b_wdata = '{hash: r_ld.hash, slot: r_rs};
                    d_we    = 1'b1;
                    d_waddr = r_rs;
                end else if (r_op == lph_pkg::OP_PUT) begin
                    if (r_hit) begin
                        d_we    = 1'b1;
                        d_wdata = '{key: r_dd.key, value: r_v, hash: r_dd.hash};
                    end else if (tgt_ok && room) begin
                        d_we    = 1'b1;
                        d_waddr = r_cnt[BW-1:0];
                        d_wdata = '{key: r_k, value: r_v, hash: r_h};
                        b_we    = 1'b1;
                        b_waddr = tgt;
                        b_wdata = '{hash: r_h, slot: r_cnt[BW-1:0]};
                    end
                end else if (r_op == lph_pkg::OP_REMOVE && r_hit &&
                             ({1'b0, r_hs} == last)) begin
                    b_we    = 1'b1;
                    b_waddr = r_hb;
                    b_wdata = '{hash: lph_pkg::HASH_TOMB, slot: r_hs};
                end
            end
            S_TOMB: begin
                b_we    = 1'b1;
                b_waddr = r_rb;
                b_wdata = '{hash: lph_pkg::HASH_TOMB, slot: r_rs};
            end
            default: begin
            end
        endcase
    end

    // load limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= lph_pkg::CNT_W'(731);
        end else if (cfg_wr) begin
            r_lim <= pwdata[lph_pkg::CNT_W-1:0];
        end
    end

    // sequencer: clear, probe, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + BW'(1);
                    if (r_idx == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_req.op;
                        r_h     <= i_req.probe_hash;
                        r_k     <= i_req.key;
                        r_v     <= i_req.value;
                        r_idx   <= i_req.probe_hash[BW-1:0];
                        r_n     <= '0;
                        r_hit   <= 1'b0;
                        r_tv    <= 1'b0;
                        r_fv    <= 1'b0;
                        r_reloc <= 1'b0;
                        r_rsp   <= '{status: early_st, value_out: '0,
                                     slot: '0, entry_count: r_cnt};
                        // answer at once, or start the probe
                        r_state <= early ? S_IDLE : S_BRD;
                    end
                end
                S_BRD: begin
                    r_state <= S_BCHK;
                end
                S_BCHK: begin
                    r_hs <= b_q.slot;
                    if (b_q.hash == lph_pkg::HASH_EMPTY) begin
                        r_fv    <= 1'b1;
                        r_free  <= r_idx;
                        r_state <= S_END;
                    end else if (cand) begin
                        r_state <= S_DCHK;
                    end else begin
                        if (b_q.hash == lph_pkg::HASH_TOMB && !r_tv) begin
                            r_tv   <= 1'b1;
                            r_tomb <= r_idx;
                        end
                        r_idx <= r_idx + BW'(1);
                        r_n   <= r_n + BW'(1);
                        r_state <= (r_n == '1) ? S_END : S_BRD;
                    end
                end
                S_DCHK: begin
                    if (d_q.key == r_k) begin
                        r_hit   <= 1'b1;
                        r_hb    <= r_idx;
                        r_dd    <= d_q;
                        r_state <= S_END;
                    end else begin
                        r_idx <= r_idx + BW'(1);
                        r_n   <= r_n + BW'(1);
                        r_state <= (r_n == '1) ? S_END : S_BRD;
                    end
                end
                S_END: begin
                    if (r_reloc) begin
                        r_state <= S_TOMB;
                    end else if (r_op == lph_pkg::OP_PUT) begin
                        r_state <= S_IDLE;
                        if (r_hit) begin
                            r_rsp.status <= lph_pkg::ST_UPDATED;
                            r_rsp.slot   <= r_hs;
                        end else if (tgt_ok && room) begin
                            r_cnt             <= r_cnt + lph_pkg::CNT_W'(1);
                            r_rsp.status      <= lph_pkg::ST_INSERTED;
                            r_rsp.slot        <= r_cnt[BW-1:0];
                            r_rsp.entry_count <= r_cnt + lph_pkg::CNT_W'(1);
                        end else begin
                            r_rsp.status <= lph_pkg::ST_FULL;
                        end
                    end else if (r_op == lph_pkg::OP_FIND) begin
                        r_state <= S_IDLE;
                        if (r_hit) begin
                            r_rsp.status    <= lph_pkg::ST_FOUND;
                            r_rsp.slot      <= r_hs;
                            r_rsp.value_out <= r_dd.value;
                        end
                    end else if (relocate) begin
                        // relocate the last dense entry into the freed slot
                        r_rb    <= r_hb;
                        r_rs    <= r_hs;
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_IDLE;
                        if (r_hit) begin
                            r_cnt             <= last;
                            r_rsp.status      <= lph_pkg::ST_REMOVED;
                            r_rsp.slot        <= r_hs;
                            r_rsp.entry_count <= last;
                        end
                    end
                end
                S_LRD: begin
                    r_state <= S_LCHK;
                end
                S_LCHK: begin
                    r_ld    <= d_q;
                    r_h     <= d_q.hash;
                    r_k     <= d_q.key;
                    r_idx   <= d_q.hash[BW-1:0];
                    r_n     <= '0;
                    r_hit   <= 1'b0;
                    r_reloc <= 1'b1;
                    r_state <= S_BRD;
                end
                S_TOMB: begin
                    r_cnt             <= last;
                    r_rsp.status      <= lph_pkg::ST_REMOVED;
                    r_rsp.slot        <= r_rs;
                    r_rsp.entry_count <= last;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a result never appears while a request is still in work
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    // entry count stays within the table
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lph_pkg::CNT_W'(lph_pkg::BUCKETS)) else $error("count overflow");

    // count moves only with an insert or remove result
    a_cnt_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) && $past(i_rst_n) |->
        o_done && (o_rsp.status == lph_pkg::ST_INSERTED ||
                   o_rsp.status == lph_pkg::ST_REMOVED))
        else $error("count changed without result");

endmodule

// ===== bench/tb_linear_probe_hash_index_top.sv =====
// Self-checking bench for linear_probe_hash_index_top: random and directed
// put/find/remove requests checked against an in-bench table predictor.
// Depends on lph_pkg and the RTL of the hash index.
`timescale 1ns / 1ps

class lph_scoreboard;
    lph_pkg::t_rsp pending[$];
    int            errors;

    // Hold the table state owned by the predictor
    logic [63:0] bkt_hash[1024];
    logic [9:0]  bkt_slot[1024];
    logic [63:0] slot_key[1024];
    logic [63:0] slot_val[1024];
    logic [63:0] slot_hash[1024];
    int unsigned entries;
    int unsigned limit;

    function new();
        for (int i = 0; i < 1024; i++) begin
            bkt_hash[i] = '0;
            bkt_slot[i] = '0;
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_hash[i] = '0;
        end
        entries = 0;
        limit = 731;
        errors = 0;
    endfunction

    // Walk the buckets; return matching bucket or -1
    function int walk(logic [63:0] h, logic [63:0] k, output int tomb, output int empty_b);
        int idx;
        tomb = -1;
        empty_b = -1;
        idx = int'(h[9:0]);
        for (int n = 0; n < 1024; n++) begin
            if (bkt_hash[idx] == lph_pkg::HASH_EMPTY) begin
                empty_b = idx;
                return -1;
            end
            if (bkt_hash[idx] == lph_pkg::HASH_TOMB) begin
                if (tomb < 0) tomb = idx;
            end else if (bkt_hash[idx] == h) begin
                if (bkt_slot[idx] < entries && slot_key[bkt_slot[idx]] == k) return idx;
            end
            idx = (idx + 1) % 1024;
        end
        return -1;
    endfunction

    // Note an accepted request and queue its expected response
    function void note_request(lph_pkg::t_req r);
        lph_pkg::t_rsp e;
        int b, t, f, tgt, s, lb, t2, f2;
        e = '0;
        e.status = lph_pkg::ST_NOT_FOUND;
        if (r.probe_hash == lph_pkg::HASH_EMPTY || r.probe_hash == lph_pkg::HASH_TOMB) begin
            e.status = lph_pkg::ST_RESERVED;
        end else if (r.op == lph_pkg::OP_PUT) begin
            if (entries + 1 >= limit) begin
                e.status = lph_pkg::ST_FULL;
            end else begin
                b = walk(r.probe_hash, r.key, t, f);
                if (b >= 0) begin
                    e.slot = bkt_slot[b];
                    slot_val[bkt_slot[b]] = r.value;
                    e.status = lph_pkg::ST_UPDATED;
                end else begin
                    tgt = (t >= 0) ? t : f;
                    if (tgt < 0 || entries >= 1024) begin
                        e.status = lph_pkg::ST_FULL;
                    end else begin
                        e.slot = entries[9:0];
                        slot_key[entries] = r.key;
                        slot_val[entries] = r.value;
                        slot_hash[entries] = r.probe_hash;
                        bkt_hash[tgt] = r.probe_hash;
                        bkt_slot[tgt] = entries[9:0];
                        entries++;
                        e.status = lph_pkg::ST_INSERTED;
                    end
                end
            end
        end else if (r.op == lph_pkg::OP_FIND) begin
            b = walk(r.probe_hash, r.key, t, f);
            if (b >= 0) begin
                e.slot = bkt_slot[b];
                e.value_out = slot_val[bkt_slot[b]];
                e.status = lph_pkg::ST_FOUND;
            end
        end else if (r.op == lph_pkg::OP_REMOVE) begin
            b = walk(r.probe_hash, r.key, t, f);
            if (b >= 0 && entries > 0) begin
                s = bkt_slot[b];
                if (s != entries - 1) begin
                    lb = walk(slot_hash[entries-1], slot_key[entries-1], t2, f2);
                    if (lb >= 0) bkt_slot[lb] = s[9:0];
                    slot_key[s] = slot_key[entries-1];
                    slot_val[s] = slot_val[entries-1];
                    slot_hash[s] = slot_hash[entries-1];
                end
                bkt_hash[b] = lph_pkg::HASH_TOMB;
                entries--;
                e.slot = s[9:0];
                e.status = lph_pkg::ST_REMOVED;
            end
        end
        e.entry_count = entries[10:0];
        pending.push_back(e);
    endfunction

    // Compare a response with the oldest expectation
    function void check_response(lph_pkg::t_rsp a);
        lph_pkg::t_rsp e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (e.status != a.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
        end
        if (e.value_out != a.value_out) begin
            $display("%0t: value_out exp %h got %h", $time, e.value_out, a.value_out);
            errors++;
        end
        if (e.slot != a.slot) begin
            $display("%0t: slot exp %0d got %0d", $time, e.slot, a.slot);
            errors++;
        end
        if (e.entry_count != a.entry_count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                     a.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_linear_probe_hash_index_top;

    localparam int WATCHDOG = 200000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    lph_pkg::t_req i_req;
    logic          o_done;
    lph_pkg::t_rsp o_rsp;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    lph_scoreboard table_sb;
    bit          calm;
    int          stall_cycles;
    logic [63:0] key_pool[16];
    logic [63:0] hash_pool[16];

    linear_probe_hash_index_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check responses and count idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) table_sb.check_response(o_rsp);
        if (start && !busy || o_done || psel) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Issue one request and wait for it to be taken; start stays high
    // until the next request, a gap or a drain
    task automatic send_request(logic [1:0] op, logic [63:0] k, logic [63:0] h,
                                logic [63:0] v);
        int gap;
        lph_pkg::t_req r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r.op = op;
        r.key = k;
        r.probe_hash = h;
        r.value = v;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        table_sb.note_request(r);
    endtask

    // Wait until every expected response has arrived
    task automatic drain();
        start <= 1'b0;
        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned lim);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= lim;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        table_sb.limit = lim & 32'h7FF;
    endtask

    // Random request biased toward a small pool of colliding keys
    task automatic random_request();
        int          p;
        logic [1:0]  op;
        logic [63:0] k;
        logic [63:0] h;
        p = $urandom_range(0, 15);
        op = $urandom_range(0, 9) < 5 ? lph_pkg::OP_PUT :
             ($urandom_range(0, 1) ? lph_pkg::OP_FIND : lph_pkg::OP_REMOVE);
        if ($urandom_range(0, 19) == 0) op = lph_pkg::OP_UNUSED;
        k = key_pool[p];
        h = hash_pool[p];
        if ($urandom_range(0, 15) == 0) begin
            k = rand64();
            h = rand64();
        end
        if ($urandom_range(0, 30) == 0) begin
            h = $urandom_range(0, 1) ? lph_pkg::HASH_EMPTY : lph_pkg::HASH_TOMB;
        end
        send_request(op, k, h, rand64());
    endtask

    initial begin
        table_sb = new();
        calm = 0;
        stall_cycles = 0;
        start = 1'b0;
        i_req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < 16; i++) begin
            key_pool[i] = rand64();
            // crowd a few bucket indexes around the wrap, some equal hashes
            hash_pool[i] = rand64() | 64'h400;
            hash_pool[i][9:0] = 10'(1020 + (i % 6));
            if (i % 5 == 0) hash_pool[i] = hash_pool[0];
        end
        key_pool[1] = '0;
        key_pool[2] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, all ops, reserved hashes, updates and relocation
        send_request(lph_pkg::OP_FIND, '0, 64'h1, '0);
        send_request(lph_pkg::OP_PUT, '0, lph_pkg::HASH_EMPTY, '1);
        send_request(lph_pkg::OP_FIND, '1, lph_pkg::HASH_TOMB, '0);
        send_request(lph_pkg::OP_REMOVE, '1, lph_pkg::HASH_TOMB, '0);
        send_request(lph_pkg::OP_PUT, '0, 64'h1, '1);
        send_request(lph_pkg::OP_PUT, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        send_request(lph_pkg::OP_PUT, 64'h5, 64'h1, 64'hA5A5);
        send_request(lph_pkg::OP_PUT, 64'h5, 64'h1, 64'h5A5A);
        send_request(lph_pkg::OP_FIND, 64'h5, 64'h1, '0);
        send_request(lph_pkg::OP_FIND, '0, 64'h1, '0);
        send_request(lph_pkg::OP_REMOVE, '0, 64'h1, '0);
        send_request(lph_pkg::OP_FIND, 64'h5, 64'h1, '0);
        send_request(lph_pkg::OP_REMOVE, 64'h9, 64'h1, '0);
        send_request(lph_pkg::OP_PUT, 64'h7, 64'h1, 64'h77);
        send_request(lph_pkg::OP_UNUSED, 64'h7, 64'h1, '0);
        send_request(lph_pkg::OP_FIND, '1, 64'hFFFF_FFFF_FFFF_FFFE, '0);
        drain();

        // A limit of 1 refuses every put, then limit just above count
        write_limit(1);
        send_request(lph_pkg::OP_PUT, 64'h7, 64'h1, 64'h1);
        send_request(lph_pkg::OP_FIND, 64'h7, 64'h1, '0);
        write_limit(5);
        repeat (4) send_request(lph_pkg::OP_PUT, rand64(), rand64() | 64'h1, rand64());
        write_limit(1024);

        for (int i = 0; i < 400; i++) begin
            if (i == 150) drain();
            if (i == 200) write_limit($urandom_range(2, 12));
            if (i == 260) write_limit(2047);
            if (i == 330) write_limit(731);
            if (i >= 360) calm = 1;
            random_request();
        end
        drain();
        repeat (20) @(posedge i_clk);
        if (table_sb.errors == 0 && table_sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
